// ----- hdl/miller_rabin_witness_test_defines.svh -----
// Assertion macros shared by the Miller-Rabin witness test RTL.
`ifndef MILLER_RABIN_WITNESS_TEST_DEFINES_SVH
`define MILLER_RABIN_WITNESS_TEST_DEFINES_SVH

// Same-cycle implication, sampled on clock, switched off while reset is high
`define MRW_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mrw check failed (same cycle)");

// Next-cycle implication, sampled on clock, switched off while reset is high
`define MRW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mrw check failed (next cycle)");

`endif

// ----- hdl/mrw_pkg.sv -----
// Package for the Miller-Rabin witness test: width default, verdict codes, FSM states.
package mrw_pkg;

   // default operand width
   localparam int unsigned NUM_WIDTH_DEFAULT = 63;

   // verdict codes
   typedef logic [1:0] verdict_type;
   localparam verdict_type VERDICT_RULE_COMPOSITE = 2'd0;
   localparam verdict_type VERDICT_IS_TWO         = 2'd1;
   localparam verdict_type VERDICT_WITNESS        = 2'd2;
   localparam verdict_type VERDICT_PASS           = 2'd3;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REDUCE,
      ST_SQ,
      ST_SQ_WAIT,
      ST_MUL,
      ST_MUL_WAIT,
      ST_DONE
   } state_type;

endpackage

// ----- hdl/mrw_mod_red.sv -----
// Bit-serial restoring reduction of the witness base modulo n.
module mrw_mod_red #(
   parameter int unsigned NUM_WIDTH = mrw_pkg::NUM_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [NUM_WIDTH-1:0] dividend,
   input  logic [NUM_WIDTH-1:0] modulus,
   output logic                 done,
   output logic [NUM_WIDTH-1:0] remainder
);

   localparam int unsigned CNT_WIDTH = $clog2(NUM_WIDTH + 1);

   logic [NUM_WIDTH-1:0] rem_ff, rem_in;
   logic [NUM_WIDTH-1:0] dvd_ff, dvd_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [NUM_WIDTH:0]   trial;
   logic [NUM_WIDTH+1:0] diff;

   // one dividend bit per cycle: shift in, subtract n if it fits
   always_comb begin
      trial   = {rem_ff, dvd_ff[NUM_WIDTH-1]};
      diff    = {1'b0, trial} - {2'b00, modulus};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         rem_in = '0;
         dvd_in = dividend;
         cnt_in = CNT_WIDTH'(NUM_WIDTH);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = diff[NUM_WIDTH+1] ? trial[NUM_WIDTH-1:0] : diff[NUM_WIDTH-1:0];
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- hdl/mrw_mod_mul.sv -----
// Bit-serial shift-and-add modular multiplier, one multiplier bit per cycle.
module mrw_mod_mul #(
   parameter int unsigned NUM_WIDTH = mrw_pkg::NUM_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [NUM_WIDTH-1:0] mul_x,
   input  logic [NUM_WIDTH-1:0] mul_y,
   input  logic [NUM_WIDTH-1:0] modulus,
   output logic                 done,
   output logic [NUM_WIDTH-1:0] product
);

   localparam int unsigned CNT_WIDTH = $clog2(NUM_WIDTH + 1);

   logic [NUM_WIDTH-1:0] x_ff, x_in;
   logic [NUM_WIDTH-1:0] y_ff, y_in;
   logic [NUM_WIDTH-1:0] acc_ff, acc_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;

   // (a + b) mod m for a, b < m
   function automatic logic [NUM_WIDTH-1:0] add_mod(input logic [NUM_WIDTH-1:0] a,
                                                    input logic [NUM_WIDTH-1:0] b,
                                                    input logic [NUM_WIDTH-1:0] m);
      logic [NUM_WIDTH:0]   sum;
      logic [NUM_WIDTH+1:0] dif;
      sum = {1'b0, a} + {1'b0, b};
      dif = {1'b0, sum} - {2'b00, m};
      add_mod = dif[NUM_WIDTH+1] ? sum[NUM_WIDTH-1:0] : dif[NUM_WIDTH-1:0];
   endfunction

   // LSB first: accumulate x when the y bit is set, double x in parallel
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         x_in   = mul_x;
         y_in   = mul_y;
         acc_in = '0;
         cnt_in = CNT_WIDTH'(NUM_WIDTH);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (y_ff[0]) begin
            acc_in = add_mod(acc_ff, x_ff, modulus);
         end
         x_in   = add_mod(x_ff, x_ff, modulus);
         y_in   = y_ff >> 1;
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- hdl/miller_rabin_witness_test.sv -----
// Top level of the Miller-Rabin witness test: sequencer and exponent datapath.
//
// Usage: drive req_number_under_test (n) and req_witness_base (a) with start high;
// the item is taken at a clock edge where start is high and busy is low. busy then
// stays high until the verdict has been shown.
// The verdict appears on rsp_verdict for exactly one cycle with rsp_valid high;
// the receiver must take it then, it cannot hold the block off.
// Verdicts: 0 composite by rule (n < 2 or even), 1 n is two, 2 the base proves
// n composite, 3 n passes this base.
// Sequence: rule cases go from the accepting edge through a check state (ST_CHECK)
// and an output state (ST_DONE). Otherwise the base is reduced modulo n, then the
// exponent n - 1 is scanned MSB first, one modular squaring per bit and one extra
// multiply per set bit, each done in the bit-serial multiplier.
// One item at a time; busy falls as the verdict is taken and the next item can be
// accepted at the next clock edge.
// Reset (synchronous, active high) returns the sequencer to idle and drops any
// item in flight; no result is given for it.
`include "miller_rabin_witness_test_defines.svh"

module miller_rabin_witness_test #(
   parameter int unsigned NUM_WIDTH = mrw_pkg::NUM_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [NUM_WIDTH-1:0] req_number_under_test,
   input  logic [NUM_WIDTH-1:0] req_witness_base,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_verdict
);

   localparam int unsigned CNT_WIDTH = $clog2(NUM_WIDTH + 1);

   mrw_pkg::state_type   state_ff, state_in;
   logic [NUM_WIDTH-1:0] n_ff, n_in;
   logic [NUM_WIDTH-1:0] a_ff, a_in;
   logic [NUM_WIDTH-1:0] base_ff, base_in;
   logic [NUM_WIDTH-1:0] acc_ff, acc_in;
   logic [NUM_WIDTH-1:0] e_ff, e_in;
   logic [CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic                 flag_ff, flag_in;
   mrw_pkg::verdict_type verdict_ff, verdict_in;

   logic                 red_go, red_done;
   logic [NUM_WIDTH-1:0] red_rem;
   logic                 mul_go, mul_done;
   logic [NUM_WIDTH-1:0] mul_x, mul_prod;

   logic n_small, n_is_two, n_even, rule_case;
   logic tail, cur_bit, last_bit;
   logic acc_is_one, acc_is_nm1, prod_is_one, nontrivial, flag_next;
   logic mul_waiting, mul_launch, operands_ok;

   // base reduction unit
   mrw_mod_red #(.NUM_WIDTH(NUM_WIDTH)) u_red (
      .clock     (clock),
      .reset     (reset),
      .go        (red_go),
      .dividend  (a_ff),
      .modulus   (n_ff),
      .done      (red_done),
      .remainder (red_rem)
   );

   // shared modular multiplier for squarings and base multiplies
   mrw_mod_mul #(.NUM_WIDTH(NUM_WIDTH)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (mul_go),
      .mul_x   (mul_x),
      .mul_y   (acc_ff),
      .modulus (n_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   // rule checks and loop conditions
   always_comb begin
      n_small     = (n_ff[NUM_WIDTH-1:1] == '0);
      n_is_two    = (n_ff == NUM_WIDTH'(2));
      n_even      = ~n_ff[0];
      rule_case   = n_small | n_is_two | n_even;
      tail        = (e_ff == '0);
      cur_bit     = e_ff[NUM_WIDTH-1];
      last_bit    = (bit_cnt_ff == CNT_WIDTH'(1));
      acc_is_one  = (acc_ff == NUM_WIDTH'(1));
      acc_is_nm1  = (acc_ff == {n_ff[NUM_WIDTH-1:1], 1'b0});
      prod_is_one = (mul_prod == NUM_WIDTH'(1));
      nontrivial  = tail & prod_is_one & ~acc_is_one & ~acc_is_nm1;
      flag_next   = flag_ff | nontrivial;
      mul_waiting = (state_ff == mrw_pkg::ST_SQ_WAIT) || (state_ff == mrw_pkg::ST_MUL_WAIT);
      mul_launch  = (state_ff == mrw_pkg::ST_SQ) || (state_ff == mrw_pkg::ST_MUL);
      operands_ok = (acc_ff < n_ff) && (base_ff < n_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mrw_pkg::ST_IDLE: begin
            if (start) state_in = mrw_pkg::ST_CHECK;
         end
         mrw_pkg::ST_CHECK: begin
            state_in = rule_case ? mrw_pkg::ST_DONE : mrw_pkg::ST_REDUCE;
         end
         mrw_pkg::ST_REDUCE: begin
            if (red_done) state_in = mrw_pkg::ST_SQ;
         end
         mrw_pkg::ST_SQ: begin
            state_in = mrw_pkg::ST_SQ_WAIT;
         end
         mrw_pkg::ST_SQ_WAIT: begin
            if (mul_done) begin
               if (cur_bit)       state_in = mrw_pkg::ST_MUL;
               else if (last_bit) state_in = mrw_pkg::ST_DONE;
               else               state_in = mrw_pkg::ST_SQ;
            end
         end
         mrw_pkg::ST_MUL: begin
            state_in = mrw_pkg::ST_MUL_WAIT;
         end
         mrw_pkg::ST_MUL_WAIT: begin
            if (mul_done) state_in = last_bit ? mrw_pkg::ST_DONE : mrw_pkg::ST_SQ;
         end
         mrw_pkg::ST_DONE: begin
            state_in = mrw_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      red_go    = 1'b0;
      mul_go    = 1'b0;
      mul_x     = acc_ff;
      unique case (state_ff)
         mrw_pkg::ST_IDLE:     busy   = 1'b0;
         mrw_pkg::ST_CHECK:    red_go = ~rule_case;
         mrw_pkg::ST_REDUCE:   ;
         mrw_pkg::ST_SQ:       mul_go = 1'b1;
         mrw_pkg::ST_SQ_WAIT:  ;
         mrw_pkg::ST_MUL: begin
            mul_go = 1'b1;
            mul_x  = base_ff;
         end
         mrw_pkg::ST_MUL_WAIT: ;
         mrw_pkg::ST_DONE:     rsp_valid = 1'b1;
      endcase
   end

   // datapath updates
   always_comb begin
      n_in       = n_ff;
      a_in       = a_ff;
      base_in    = base_ff;
      acc_in     = acc_ff;
      e_in       = e_ff;
      bit_cnt_in = bit_cnt_ff;
      flag_in    = flag_ff;
      verdict_in = verdict_ff;
      unique case (state_ff)
         mrw_pkg::ST_IDLE: begin
            if (start) begin
               n_in = req_number_under_test;
               a_in = req_witness_base;
            end
         end
         mrw_pkg::ST_CHECK: begin
            if (n_is_two) verdict_in = mrw_pkg::VERDICT_IS_TWO;
            else          verdict_in = mrw_pkg::VERDICT_RULE_COMPOSITE;
         end
         mrw_pkg::ST_REDUCE: begin
            // exponent n - 1, acc starts at 1
            if (red_done) begin
               base_in    = red_rem;
               acc_in     = NUM_WIDTH'(1);
               e_in       = {n_ff[NUM_WIDTH-1:1], 1'b0};
               bit_cnt_in = CNT_WIDTH'(NUM_WIDTH);
               flag_in    = 1'b0;
            end
         end
         mrw_pkg::ST_SQ_WAIT: begin
            // squaring done; in the trailing zeros look for a nontrivial root of 1
            if (mul_done) begin
               acc_in  = mul_prod;
               flag_in = flag_next;
               if (!cur_bit) begin
                  e_in       = e_ff << 1;
                  bit_cnt_in = bit_cnt_ff - CNT_WIDTH'(1);
                  if (flag_next || !prod_is_one) verdict_in = mrw_pkg::VERDICT_WITNESS;
                  else                           verdict_in = mrw_pkg::VERDICT_PASS;
               end
            end
         end
         mrw_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               acc_in     = mul_prod;
               e_in       = e_ff << 1;
               bit_cnt_in = bit_cnt_ff - CNT_WIDTH'(1);
               if (flag_ff || !prod_is_one) verdict_in = mrw_pkg::VERDICT_WITNESS;
               else                         verdict_in = mrw_pkg::VERDICT_PASS;
            end
         end
         mrw_pkg::ST_SQ, mrw_pkg::ST_MUL, mrw_pkg::ST_DONE: ;
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      a_ff       <= a_in;
      base_ff    <= base_in;
      acc_ff     <= acc_in;
      e_ff       <= e_in;
      bit_cnt_ff <= bit_cnt_in;
      flag_ff    <= flag_in;
      verdict_ff <= verdict_in;
   end

   assign rsp_verdict = verdict_ff;

   // checks
   `MRW_ASSERT_NEXT(a_accept_to_check, start && !busy, state_ff == mrw_pkg::ST_CHECK)
   `MRW_ASSERT_NEXT(a_single_result, rsp_valid, !rsp_valid)
   `MRW_ASSERT_IMPL(a_mul_done_waited, mul_done, mul_waiting)
   `MRW_ASSERT_IMPL(a_operands_reduced, mul_launch, operands_ok)

endmodule
